/* hdl/trade_order_message_parser_macros.svh */
// assertion macros for the trade order message parser
// no dependencies; included by modules that carry concurrent checks
`ifndef TRADE_ORDER_MESSAGE_PARSER_MACROS_SVH
`define TRADE_ORDER_MESSAGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define TROP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("trop check failed");

// next-cycle implication, disabled in reset
`define TROP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("trop check failed");

`else

`define TROP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TROP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/trop_pkg.sv */
// shared types and constants of the trade order message parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package trop_pkg;

    // message characters
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_L    = 8'h4C;
    localparam logic [7:0] CHAR_LS   = 8'h73;
    localparam logic [7:0] CHAR_US   = 8'h53;

    // order kinds
    localparam logic [1:0] KIND_MARKET     = 2'd0;
    localparam logic [1:0] KIND_LIMIT      = 2'd1;
    localparam logic [1:0] KIND_STOP_LOSS  = 2'd2;
    localparam logic [1:0] KIND_STOP_LIMIT = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_TRADE    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_KIND = 3'd2;
    localparam logic [2:0] ST_TICKER_LONG  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED    = 3'd4;

    // bus widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 216;
    localparam int M_TUSER_W = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // one classified byte
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] agent;
        logic        last;
        logic        is_t;
        logic        is_b;
        logic        is_dot;
        logic        kind_ok;
        logic [1:0]  kind;
    } trop_class_t;

endpackage

`default_nettype wire

/* hdl/trade_order_message_parser.sv */
// top level of the trade order message parser: front, queue and back
// depends on trop_pkg, trop_front, trop_fifo, trop_back
// result path: the last byte of a message is written into the queue, then popped by the back into the result register
// throughput: one byte per cycle while the queue is not full; the back parses one queued byte each cycle
// a last byte waits in the queue only while the previous result is not yet taken
// reset: synchronous, active low; clears queue pointers, parse state, counter and m_tvalid
`timescale 1ns / 1ps
`default_nettype none

module trade_order_message_parser
    import trop_pkg::*;
#(
    parameter int MAX_TICKER_CHARS = 8,
    parameter int NUMBER_WIDTH     = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // byte stream in
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // byte_in [7:0], agent_id [23:8]
    input  wire logic                 s_tlast,   // last_byte
    // order results out
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // order_number [31:0], agent_out [47:32], order_kind [49:48], is_buy [50],
    // all_or_none [51], immediate_or_cancel [52], ticker_chars [116:53],
    // quantity [148:117], price_first [180:149], price_second [212:181], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser    // status [2:0]
);

    // front to queue
    trop_class_t front_cls;
    logic        push;
    logic        queue_full;

    // queue to back
    trop_class_t head_cls;
    logic        queue_empty;
    logic        pop;

    // byte decode, ready follows queue space only
    trop_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .cls        (front_cls)
    );

    // decouples input acceptance from a stalled result
    trop_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (front_cls),
        .pop     (pop),
        .rd_data (head_cls),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // parse state, accumulators, order counter and result register
    trop_back #(
        .MAX_TICKER_CHARS (MAX_TICKER_CHARS),
        .NUMBER_WIDTH     (NUMBER_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cls      (head_cls),
        .empty    (queue_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* hdl/trop_front.sv */
// front: takes input transactions and classifies each message byte
// depends on trop_pkg
`timescale 1ns / 1ps
`default_nettype none

module trop_front
    import trop_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // byte_in, agent_id
    input  wire logic                 s_tlast,
    input  wire logic                 queue_full,
    output logic                      push,
    output trop_class_t               cls
);

    logic [7:0] b;

    assign b        = s_tdata[7:0];
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        cls         = '0;
        cls.data    = b;
        cls.agent   = s_tdata[23:8];
        cls.last    = s_tlast;
        cls.is_t    = (b == CHAR_T);
        cls.is_b    = (b == CHAR_B);
        cls.is_dot  = (b == CHAR_DOT);
        cls.kind_ok = 1'b1;
        unique case (b)
            CHAR_M:  cls.kind = KIND_MARKET;
            CHAR_L:  cls.kind = KIND_LIMIT;
            CHAR_LS: cls.kind = KIND_STOP_LOSS;
            CHAR_US: cls.kind = KIND_STOP_LIMIT;
            default: begin
                cls.kind    = KIND_MARKET;
                cls.kind_ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/trop_fifo.sv */
// short queue of classified bytes between front and back
// depends on trop_pkg
`timescale 1ns / 1ps
`default_nettype none

module trop_fifo
    import trop_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire trop_class_t wr_data,
    input  wire logic        pop,
    output trop_class_t      rd_data,
    output logic             full,
    output logic             empty
);

    trop_class_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       wr_ptr_reg;
    logic [QUEUE_AW-1:0]       rd_ptr_reg;
    logic [QUEUE_AW:0]         count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/trop_back.sv */
// back: message parse state, number accumulation and the result register
// depends on trop_pkg and trade_order_message_parser_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "trade_order_message_parser_macros.svh"

module trop_back
    import trop_pkg::*;
#(
    parameter int MAX_TICKER_CHARS = 8,
    parameter int NUMBER_WIDTH     = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire trop_class_t          cls,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser
);

    localparam logic [3:0] TICK_LIMIT = 4'(MAX_TICKER_CHARS);

    // header byte positions
    localparam logic [2:0] POS_TRADE = 3'd0;
    localparam logic [2:0] POS_KIND  = 3'd1;
    localparam logic [2:0] POS_DIR   = 3'd2;
    localparam logic [2:0] POS_AON   = 3'd3;
    localparam logic [2:0] POS_IOC   = 3'd4;
    localparam logic [2:0] POS_BODY  = 3'd5;

    // body phases
    localparam logic [1:0] PH_TICKER = 2'd0;
    localparam logic [1:0] PH_NUM1   = 2'd1;

    typedef logic [NUMBER_WIDTH-1:0] num_t;

    function automatic logic [1:0] nums_for_kind(input logic [1:0] k);
        logic [1:0] n;
        n = 2'd2;
        if (k == KIND_MARKET) n = 2'd1;
        if (k == KIND_STOP_LIMIT) n = 2'd3;
        return n;
    endfunction

    function automatic logic [31:0] to_u32(input num_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

    logic [2:0]  pos_reg,    pos_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [63:0] tick_reg,   tick_next;
    logic [3:0]  len_reg,    len_next;
    num_t        acc_reg [3];
    num_t        acc_next [3];
    logic [15:0] agent_reg,  agent_next;
    logic [1:0]  kind_reg,   kind_next;
    logic        buy_reg,    buy_next;
    logic        aon_reg,    aon_next;
    logic        ioc_reg,    ioc_next;
    logic        known_reg,  known_next;
    logic [2:0]  err_reg,    err_next;
    logic [31:0] counter_reg, counter_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic [1:0]  idx;
    logic [1:0]  count_now;
    logic [2:0]  status;
    logic [31:0] number;
    logic [M_TDATA_W-1:0] out_data;

    // a last byte waits while the result register is still held
    assign pop      = !empty && (!cls.last || !m_valid_reg || m_tready);
    assign idx      = phase_reg - 2'd1;
    assign count_now = nums_for_kind(kind_reg);

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        agent_next = agent_reg;
        kind_next  = kind_reg;
        buy_next   = buy_reg;
        aon_next   = aon_reg;
        ioc_next   = ioc_reg;
        known_next = known_reg;
        err_next   = err_reg;

        if (pos_reg == POS_TRADE) begin
            agent_next = cls.agent;
        end

        if (err_reg == ST_OK) begin
            unique case (pos_reg)
                POS_TRADE: begin
                    if (!cls.is_t) err_next = ST_NOT_TRADE;
                end
                POS_KIND: begin
                    if (cls.kind_ok) begin
                        kind_next  = cls.kind;
                        known_next = 1'b1;
                    end else begin
                        err_next = ST_UNKNOWN_KIND;
                    end
                end
                POS_DIR: buy_next = cls.is_b;
                POS_AON: aon_next = cls.is_t;
                POS_IOC: ioc_next = cls.is_t;
                default: begin
                    if (phase_reg == PH_TICKER) begin
                        if (cls.is_dot) begin
                            phase_next = PH_NUM1;
                        end else if (len_reg >= TICK_LIMIT) begin
                            err_next = ST_TICKER_LONG;
                        end else begin
                            tick_next[{3'd7 - len_reg[2:0], 3'b000} +: 8] = cls.data;
                            len_next = len_reg + 4'd1;
                        end
                    end else if (phase_reg < count_now && cls.is_dot) begin
                        phase_next = phase_reg + 2'd1;
                    end else begin
                        // times ten as two shifts, then the digit offset
                        acc_next[idx] = (acc_reg[idx] << 3) + (acc_reg[idx] << 1)
                                      + NUMBER_WIDTH'(cls.data)
                                      - NUMBER_WIDTH'(CHAR_ZERO);
                    end
                end
            endcase
            if (pos_reg < POS_BODY) pos_next = pos_reg + 3'd1;
        end
    end

    always_comb begin
        if (err_next != ST_OK) begin
            status = err_next;
        end else if (pos_next == POS_BODY && known_next
                     && phase_next == nums_for_kind(kind_next)) begin
            status = ST_OK;
        end else begin
            status = ST_TRUNCATED;
        end
        number       = known_next ? counter_reg : 32'd0;
        counter_next = known_next ? counter_reg + 32'd1 : counter_reg;
        out_data = {3'b000, to_u32(acc_next[2]), to_u32(acc_next[1]),
                    to_u32(acc_next[0]), tick_next, ioc_next, aon_next,
                    buy_next, kind_next, agent_next, number};
        if (pop && cls.last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_TRADE;
            phase_reg   <= PH_TICKER;
            tick_reg    <= '0;
            len_reg     <= '0;
            acc_reg     <= '{default: '0};
            agent_reg   <= '0;
            kind_reg    <= KIND_MARKET;
            buy_reg     <= 1'b0;
            aon_reg     <= 1'b0;
            ioc_reg     <= 1'b0;
            known_reg   <= 1'b0;
            err_reg     <= ST_OK;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop && cls.last) begin
                pos_reg     <= POS_TRADE;
                phase_reg   <= PH_TICKER;
                tick_reg    <= '0;
                len_reg     <= '0;
                acc_reg     <= '{default: '0};
                agent_reg   <= '0;
                kind_reg    <= KIND_MARKET;
                buy_reg     <= 1'b0;
                aon_reg     <= 1'b0;
                ioc_reg     <= 1'b0;
                known_reg   <= 1'b0;
                err_reg     <= ST_OK;
                counter_reg <= counter_next;
            end else if (pop) begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                len_reg     <= len_next;
                acc_reg     <= acc_next;
                agent_reg   <= agent_next;
                kind_reg    <= kind_next;
                buy_reg     <= buy_next;
                aon_reg     <= aon_next;
                ioc_reg     <= ioc_next;
                known_reg   <= known_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && cls.last) begin
            m_data_reg <= out_data;
            m_user_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `TROP_ASSERT_IMPL(a_phase_bound, aclk, aresetn, 1'b1, phase_reg <= count_now)
    `TROP_ASSERT_IMPL(a_ticker_bound, aclk, aresetn, 1'b1, len_reg <= TICK_LIMIT)
    `TROP_ASSERT_IMPL(a_header_first, aclk, aresetn, pos_reg < POS_BODY, phase_reg == PH_TICKER && len_reg == 4'd0)
    `TROP_ASSERT_NEXT(a_counter_step, aclk, aresetn, pop && cls.last && known_next, counter_reg == $past(counter_reg) + 32'd1)
    `TROP_ASSERT_NEXT(a_counter_hold, aclk, aresetn, !(pop && cls.last), counter_reg == $past(counter_reg))

endmodule

`default_nettype wire

/* bench/tb.sv */
// self-checking bench for trade_order_message_parser: directed and random order messages
// depends on trop_pkg and the parser rtl; a built-in byte-level order predictor checks results
`timescale 1ns / 1ps

module tb;
    import trop_pkg::*;

    localparam int TICKER_MAX = 8;
    localparam int STALL_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES = 10;    // extra cycles after the last result
    localparam int LOG_CAP = 40;         // mismatch lines printed at most

    // one parsed order as the result channel carries it
    typedef struct {
        logic [31:0] number;
        logic [15:0] agent;
        logic [1:0]  kind;
        logic        buy;
        logic        aon;
        logic        ioc;
        logic [63:0] ticker;
        logic [31:0] qty;
        logic [31:0] price1;
        logic [31:0] price2;
        logic [2:0]  status;
    } order_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // predictor state, one copy of the parser's message context
    logic [2:0]  hdr_pos;
    logic [2:0]  fld_phase;
    logic [63:0] tick_bits;
    logic [3:0]  tick_len;
    logic [31:0] num_acc [3];
    logic [15:0] lat_agent;
    logic [1:0]  lat_kind;
    logic        lat_buy, lat_aon, lat_ioc, lat_known;
    logic [31:0] next_order_no;
    logic [2:0]  first_err;

    order_t      pending_orders [$];
    logic [7:0]  msg_bytes [$];

    // pacing knobs shared with the sender and the stall process
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    int mismatches = 0;
    int bytes_sent = 0;
    int orders_seen = 0;
    int status_hits [5] = '{0, 0, 0, 0, 0};
    int quiet_cycles = 0;

    always #10 aclk = ~aclk;

    trade_order_message_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // how many numbers follow the ticker for an order kind
    function automatic logic [2:0] numbers_for(input logic [1:0] kind);
        if (kind == KIND_MARKET) return 3'd1;
        if (kind == KIND_STOP_LIMIT) return 3'd3;
        return 3'd2;
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        while (r == avoid) r = 8'($urandom_range(255));
        return r;
    endfunction

    task automatic clear_context();
        hdr_pos = '0;
        fld_phase = '0;
        tick_bits = '0;
        tick_len = '0;
        num_acc[0] = '0;
        num_acc[1] = '0;
        num_acc[2] = '0;
        lat_agent = '0;
        lat_kind = KIND_MARKET;
        lat_buy = 1'b0;
        lat_aon = 1'b0;
        lat_ioc = 1'b0;
        lat_known = 1'b0;
        first_err = ST_OK;
    endtask

    // advance the order context by one accepted byte; on the last byte queue the order
    task automatic track_order_byte(input logic [7:0] b, input logic last, input logic [15:0] agent);
        logic [2:0] idx;
        int         sh;
        order_t     o;
        if (hdr_pos == 3'd0) begin
            lat_agent = agent;
            lat_kind = KIND_MARKET;
            lat_buy = 1'b0;
            lat_aon = 1'b0;
            lat_ioc = 1'b0;
            lat_known = 1'b0;
        end
        // once an error is latched the rest of the message is ignored
        if (first_err == ST_OK) begin
            case (hdr_pos)
                3'd0: begin
                    if (b != CHAR_T) first_err = ST_NOT_TRADE;
                end
                3'd1: begin
                    lat_known = 1'b1;
                    if (b == CHAR_M) lat_kind = KIND_MARKET;
                    else if (b == CHAR_L) lat_kind = KIND_LIMIT;
                    else if (b == CHAR_LS) lat_kind = KIND_STOP_LOSS;
                    else if (b == CHAR_US) lat_kind = KIND_STOP_LIMIT;
                    else begin
                        lat_known = 1'b0;
                        first_err = ST_UNKNOWN_KIND;
                    end
                end
                3'd2: if (b == CHAR_B) lat_buy = 1'b1;
                3'd3: if (b == CHAR_T) lat_aon = 1'b1;
                3'd4: if (b == CHAR_T) lat_ioc = 1'b1;
                default: begin
                    if (fld_phase == 3'd0) begin
                        if (b == CHAR_DOT) begin
                            fld_phase = 3'd1;
                        end else if (int'(tick_len) >= TICKER_MAX) begin
                            first_err = ST_TICKER_LONG;
                        end else begin
                            sh = (7 - int'(tick_len)) * 8;
                            tick_bits = tick_bits | ({56'd0, b} << sh);
                            tick_len = tick_len + 4'd1;
                        end
                    end else begin
                        idx = fld_phase - 3'd1;
                        if (idx > 3'd2) idx = 3'd2;
                        // dots inside the last number are just accumulated
                        if ((idx + 3'd1) < numbers_for(lat_kind) && b == CHAR_DOT)
                            fld_phase = fld_phase + 3'd1;
                        else
                            num_acc[idx] = num_acc[idx] * 32'd10 + {24'd0, b} - 32'd48;
                    end
                end
            endcase
            if (hdr_pos < 3'd5) hdr_pos = hdr_pos + 3'd1;
        end
        if (last) begin
            if (first_err != ST_OK)
                o.status = first_err;
            else if (hdr_pos >= 3'd5 && fld_phase == numbers_for(lat_kind) && lat_known)
                o.status = ST_OK;
            else
                o.status = ST_TRUNCATED;
            o.number = '0;
            if (lat_known) begin
                o.number = next_order_no;
                next_order_no = next_order_no + 32'd1;
            end
            o.agent = lat_agent;
            o.kind = lat_kind;
            o.buy = lat_buy;
            o.aon = lat_aon;
            o.ioc = lat_ioc;
            o.ticker = tick_bits;
            o.qty = num_acc[0];
            o.price1 = num_acc[1];
            o.price2 = num_acc[2];
            pending_orders.push_back(o);
            clear_context();
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= LOG_CAP)
            $display("mismatch in order %0d, %s: got %h, expected %h",
                     orders_seen, field, got, want);
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) flag_mismatch(field, got, want);
    endtask

    // result checker: every accepted result against the oldest pending order
    always @(posedge aclk) begin
        order_t o;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_orders.size() == 0) begin
                flag_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                o = pending_orders.pop_front();
                check_field("order_number", m_tdata[31:0], o.number);
                check_field("agent_out", m_tdata[47:32], o.agent);
                check_field("order_kind", m_tdata[49:48], o.kind);
                check_field("is_buy", m_tdata[50], o.buy);
                check_field("all_or_none", m_tdata[51], o.aon);
                check_field("immediate_or_cancel", m_tdata[52], o.ioc);
                check_field("ticker_chars", m_tdata[116:53], o.ticker);
                check_field("quantity", m_tdata[148:117], o.qty);
                check_field("price_first", m_tdata[180:149], o.price1);
                check_field("price_second", m_tdata[212:181], o.price2);
                check_field("status", m_tuser[2:0], o.status);
                if (o.status <= ST_TRUNCATED) status_hits[o.status]++;
            end
            orders_seen++;
        end
    end

    // receiver: random stalls, or a long counted hold-off when one is requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // send one byte; entered just after a falling edge, returns just after one
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] agent);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {agent, b};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        track_order_byte(b, last, agent);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // send msg_bytes as one message; only the first byte's agent is latched
    task automatic send_message(input logic [15:0] agent);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1,
                      (i == 0) ? agent : 16'($urandom_range(65535)));
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_orders.size() != 0) @(negedge aclk);
    endtask

    task automatic load_text(input string txt);
        msg_bytes.delete();
        for (int i = 0; i < txt.len(); i++) msg_bytes.push_back(txt[i]);
    endtask

    // random message: mostly well formed, the rest broken in one of several ways
    task automatic build_order_msg();
        int          pick, nums, nd, tl, cut;
        logic [1:0]  kind;
        logic [7:0]  letters [4];
        logic [7:0]  r;
        letters = '{CHAR_M, CHAR_L, CHAR_LS, CHAR_US};
        msg_bytes.delete();
        pick = $urandom_range(99);
        kind = 2'($urandom_range(3));
        msg_bytes.push_back(CHAR_T);
        msg_bytes.push_back(letters[kind]);
        msg_bytes.push_back(($urandom_range(1) != 0) ? CHAR_B : 8'($urandom_range(255)));
        msg_bytes.push_back(($urandom_range(1) != 0) ? CHAR_T : 8'($urandom_range(255)));
        msg_bytes.push_back(($urandom_range(1) != 0) ? CHAR_T : 8'($urandom_range(255)));
        // ticker, over length in the ticker-too-long slice
        tl = (pick >= 14 && pick < 20) ? $urandom_range(11, 9) : $urandom_range(TICKER_MAX);
        for (int i = 0; i < tl; i++) begin
            if ($urandom_range(9) < 8) r = 8'("A") + 8'($urandom_range(25));
            else r = random_byte_except(CHAR_DOT);
            msg_bytes.push_back(r);
        end
        msg_bytes.push_back(CHAR_DOT);
        nums = int'(numbers_for(kind));
        for (int n = 0; n < nums; n++) begin
            nd = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(6);
            for (int d = 0; d < nd; d++) begin
                if ($urandom_range(19) < 17) r = CHAR_ZERO + 8'($urandom_range(9));
                else if (n == nums - 1 && $urandom_range(2) == 0) r = CHAR_DOT;
                else r = random_byte_except(CHAR_DOT);
                msg_bytes.push_back(r);
            end
            if (n != nums - 1) msg_bytes.push_back(CHAR_DOT);
        end
        if (pick < 8) begin
            msg_bytes[0] = random_byte_except(CHAR_T);
        end else if (pick < 14) begin
            r = 8'($urandom_range(255));
            while (r == CHAR_M || r == CHAR_L || r == CHAR_LS || r == CHAR_US)
                r = 8'($urandom_range(255));
            msg_bytes[1] = r;
        end else if (pick >= 20 && pick < 30) begin
            // cut short anywhere, a bare leading byte included
            cut = $urandom_range(msg_bytes.size() - 1, 1);
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end
    endtask

    // directed: not-trade, unknown-kind, truncated and ok statuses, empty fields, extreme bytes and agents
    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        load_text("X");
        send_message(16'hFFFF);
        load_text("T");
        send_message(16'h0000);
        load_text("TQ");
        send_message(16'hA5A5);
        load_text("TMBTF.");
        send_message(16'h5A5A);
        // stop-limit with extreme bytes in numbers and a dot inside the last one
        msg_bytes.delete();
        msg_bytes = '{CHAR_T, CHAR_US, 8'hFF, CHAR_T, CHAR_T, CHAR_DOT, 8'hFF, CHAR_DOT,
                      8'h00, CHAR_DOT, 8'h39, CHAR_DOT, 8'h39};
        send_message(16'h8001);
        go_quiet();
        wait_drained();
    endtask

    task automatic test_random(input int idle, input int stall, input int n_bytes);
        int start;
        idle_pct = idle;
        stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_order_msg();
            send_message(16'($urandom_range(65535)));
        end
        go_quiet();
        wait_drained();
    endtask

    // receiver holds off long enough that the input side fills and stalls
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 4; i++) begin
            build_order_msg();
            send_message(16'($urandom_range(65535)));
        end
        go_quiet();
        wait_drained();
    endtask

    initial begin
        clear_context();
        next_order_no = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(0, 0, 130);
        test_random(65, 0, 130);
        test_random(0, 65, 130);
        test_random(24, 24, 130);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d bytes in %0d orders over idle, stall and hold-off phases",
                 bytes_sent, orders_seen);
        $display("statuses ok %0d, not trade %0d, unknown kind %0d, long ticker %0d, truncated %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
        if (mismatches == 0 && pending_orders.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d orders outstanding", mismatches, pending_orders.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
